// ----- src/bck_pkg.sv -----
// ---------------------------------------------------------------------------
// bck_pkg: shared definitions for the bc cubic kernel weight core
// widths, register codes, reset values and the words passed between stages
// ---------------------------------------------------------------------------
`default_nettype none

package bck_pkg;

    // field and register widths
    localparam int X_W        = 24;
    localparam int ORD_W      = 2;
    localparam int SHAPE_W    = 20;
    localparam int INV_W      = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WEIGHT_W   = 32;

    // t = |x| * inv_scale in Q32, evaluated in Q24
    localparam int T32_W      = X_W + INV_W;
    localparam int FRAC_SHIFT = 8;
    localparam int T_W        = 25;
    localparam int SUP_BIT    = T_W + FRAC_SHIFT;

    // horner datapath
    localparam int COEF_W  = 28;
    localparam int ACC_W   = 38;
    localparam int SPLIT   = 19;
    localparam int PH_W    = ACC_W - SPLIT + T_W + 1;
    localparam int PL_W    = SPLIT + T_W;
    localparam int PROD_W  = 64;
    localparam int Q24_SH  = 24;
    localparam int MAG_W   = ACC_W - 1;

    // scale chain, value capped at 2^(VAL_W-1)
    localparam int VAL_W   = 84;
    localparam int CHUNK_W = 21;
    localparam int N_CHUNK = VAL_W / CHUNK_W;
    localparam int PP_W    = CHUNK_W + INV_W;
    localparam int WIDE_W  = VAL_W + INV_W;
    localparam int V_SHIFT = 48;
    localparam logic [VAL_W-1:0] VAL_CAP = {1'b1, {(VAL_W-1){1'b0}}};

    // divide by six as a halving and a divide by three
    localparam int U_W     = VAL_W - V_SHIFT - 1;
    localparam int DB_W    = 16;
    localparam int DA_W    = 17;
    localparam int DS_W    = DA_W + 1;
    localparam int A21_W   = 32;
    localparam int DIV3_SH = 19;
    localparam logic [U_W-1:0]   SAT_U   = 35'h1_8000_0000;
    localparam logic [14:0]      K_21845 = 15'd21845;
    localparam logic [DS_W-1:0]  DIV3_M  = 18'd174763;

    localparam logic [WEIGHT_W-1:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] W_MIN = 32'h8000_0000;

    localparam logic [INV_W-1:0]         ONE_Q16  = 24'd65536;
    localparam logic signed [COEF_W-1:0] ONE_COEF = 28'sd65536;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE_B   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE_C   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE = 2'd3;

    // derivative orders
    localparam logic [ORD_W-1:0] ORD_KERNEL = 2'd0;
    localparam logic [ORD_W-1:0] ORD_FIRST  = 2'd1;
    localparam logic [ORD_W-1:0] ORD_SECOND = 2'd2;

    // reset values
    localparam logic [ORD_W-1:0]          ORD_RST     = 2'd0;
    localparam logic signed [SHAPE_W-1:0] SHAPE_B_RST = 20'sd0;
    localparam logic signed [SHAPE_W-1:0] SHAPE_C_RST = 20'sd32768;
    localparam logic [INV_W-1:0]          INV_RST     = 24'd65536;

    // stages from s_axis accept to m_axis output register
    localparam int PIPE_DEPTH = 17;
    localparam int DEPTH_W    = 5;

    typedef struct packed {
        logic [ORD_W-1:0]          ord;
        logic signed [SHAPE_W-1:0] shape_b;
        logic signed [SHAPE_W-1:0] shape_c;
        logic [INV_W-1:0]          inv_scale;
    } cfg_t;

    typedef struct packed {
        logic last;
        logic odd_neg;
        logic in_sup;
    } side_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]  acc;
        logic [T_W-1:0]           t;
        logic signed [COEF_W-1:0] cn0;
        logic signed [COEF_W-1:0] cn1;
        logic signed [COEF_W-1:0] cn2;
        side_t                    side;
    } hn_t;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [ORD_W-1:0] pow;
        logic             neg;
        logic             in_sup;
        logic             last;
    } sc_t;

endpackage

`default_nettype wire

// ----- src/bck_coef.sv -----
// ---------------------------------------------------------------------------
// bck_coef: offset to t and piece coefficients
// stage a forms |x| * inv_scale, stage b picks the piece and its coefficients
// ---------------------------------------------------------------------------
`default_nettype none

module bck_coef (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bck_pkg::cfg_t         cfg,
    input  logic                  in_vld,
    output logic                  in_rdy,
    input  logic [bck_pkg::X_W-1:0] x,
    input  logic                  last,
    output logic                  out_vld,
    input  logic                  out_rdy,
    output bck_pkg::hn_t          out
);
    import bck_pkg::*;

    logic                     vld_a_reg;
    logic                     vld_b_reg;
    logic                     en_a;
    logic                     en_b;
    logic [X_W-1:0]           ax;
    logic [T32_W-1:0]         t32_reg;
    logic [T32_W-1:0]         t32_next;
    logic                     last_a_reg;
    logic                     odd_neg_a_reg;
    logic                     outer;
    logic signed [COEF_W-1:0] bs;
    logic signed [COEF_W-1:0] cs;
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c0;
    hn_t                      hn_reg;
    hn_t                      hn_next;

    assign en_b    = ~vld_b_reg | out_rdy;
    assign en_a    = ~vld_a_reg | en_b;
    assign in_rdy  = en_a;
    assign out_vld = vld_b_reg;
    assign out     = hn_reg;

    assign ax       = x[X_W-1] ? (~x + 1'b1) : x;
    assign t32_next = ax * cfg.inv_scale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                vld_a_reg <= in_vld;
            end
            if (en_b)
            begin
                vld_b_reg <= vld_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            t32_reg       <= t32_next;
            last_a_reg    <= last;
            odd_neg_a_reg <= (cfg.ord == ORD_FIRST) && x[X_W-1];
        end
        if (en_b)
        begin
            hn_reg <= hn_next;
        end
    end

    assign outer = t32_reg[SUP_BIT-1];
    assign bs    = {{(COEF_W-SHAPE_W){cfg.shape_b[SHAPE_W-1]}}, cfg.shape_b};
    assign cs    = {{(COEF_W-SHAPE_W){cfg.shape_c[SHAPE_W-1]}}, cfg.shape_c};

    // six times the published piece, coefficients in q16
    always_comb
    begin
        c3 = '0;
        c2 = '0;
        c1 = '0;
        c0 = '0;
        unique case (cfg.ord)
            ORD_KERNEL:
            begin
                if (outer)
                begin
                    c3 = -bs - 28'sd6 * cs;
                    c2 = 28'sd6 * bs + 28'sd30 * cs;
                    c1 = -(28'sd12 * bs) - 28'sd48 * cs;
                    c0 = 28'sd8 * bs + 28'sd24 * cs;
                end
                else
                begin
                    c3 = 28'sd12 * ONE_COEF - 28'sd9 * bs - 28'sd6 * cs;
                    c2 = -(28'sd18 * ONE_COEF) + 28'sd12 * bs + 28'sd6 * cs;
                    c0 = 28'sd6 * ONE_COEF - 28'sd2 * bs;
                end
            end
            ORD_FIRST:
            begin
                if (outer)
                begin
                    c2 = -(28'sd3 * bs) - 28'sd18 * cs;
                    c1 = 28'sd12 * bs + 28'sd60 * cs;
                    c0 = -(28'sd12 * bs) - 28'sd48 * cs;
                end
                else
                begin
                    c2 = 28'sd36 * ONE_COEF - 28'sd27 * bs - 28'sd18 * cs;
                    c1 = -(28'sd36 * ONE_COEF) + 28'sd24 * bs + 28'sd12 * cs;
                end
            end
            default:
            begin
                if (outer)
                begin
                    c1 = -(28'sd6 * bs) - 28'sd36 * cs;
                    c0 = 28'sd12 * bs + 28'sd60 * cs;
                end
                else
                begin
                    c1 = 28'sd72 * ONE_COEF - 28'sd54 * bs - 28'sd36 * cs;
                    c0 = -(28'sd36 * ONE_COEF) + 28'sd24 * bs + 28'sd12 * cs;
                end
            end
        endcase
    end

    always_comb
    begin
        hn_next             = '0;
        hn_next.acc         = {{(ACC_W-COEF_W-FRAC_SHIFT){c3[COEF_W-1]}}, c3,
                               {FRAC_SHIFT{1'b0}}};
        hn_next.t           = t32_reg[SUP_BIT-1:FRAC_SHIFT];
        hn_next.cn0         = c2;
        hn_next.cn1         = c1;
        hn_next.cn2         = c0;
        hn_next.side.last   = last_a_reg;
        hn_next.side.odd_neg = odd_neg_a_reg;
        hn_next.side.in_sup = (t32_reg[T32_W-1:SUP_BIT] == '0);
    end

endmodule

`default_nettype wire

// ----- src/bck_horner_step.sv -----
// ---------------------------------------------------------------------------
// bck_horner_step: one horner step, acc = floor(acc * t) + coefficient
// multiply stage with split partial products, then combine and add stage
// ---------------------------------------------------------------------------
`default_nettype none

module bck_horner_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_vld,
    output logic         in_rdy,
    input  bck_pkg::hn_t in_word,
    output logic         out_vld,
    input  logic         out_rdy,
    output bck_pkg::hn_t out_word
);
    import bck_pkg::*;

    logic                     vld_m_reg;
    logic                     vld_a_reg;
    logic                     en_m;
    logic                     en_a;
    logic signed [PH_W-1:0]   ph_reg;
    logic signed [PH_W-1:0]   ph_next;
    logic [PL_W-1:0]          pl_reg;
    logic [PL_W-1:0]          pl_next;
    hn_t                      m_reg;
    hn_t                      out_reg;
    hn_t                      out_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  coef_ext;

    assign en_a     = ~vld_a_reg | out_rdy;
    assign en_m     = ~vld_m_reg | en_a;
    assign in_rdy   = en_m;
    assign out_vld  = vld_a_reg;
    assign out_word = out_reg;

    // upper half signed, lower half unsigned
    assign ph_next = $signed(in_word.acc[ACC_W-1:SPLIT]) * $signed({1'b0, in_word.t});
    assign pl_next = in_word.acc[SPLIT-1:0] * in_word.t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
            vld_a_reg <= 1'b0;
        end
        else
        begin
            if (en_m)
            begin
                vld_m_reg <= in_vld;
            end
            if (en_a)
            begin
                vld_a_reg <= vld_m_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_m)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            m_reg  <= in_word;
        end
        if (en_a)
        begin
            out_reg <= out_next;
        end
    end

    assign prod = ($signed({{(PROD_W-PH_W){ph_reg[PH_W-1]}}, ph_reg}) <<< SPLIT)
                + $signed({{(PROD_W-PL_W){1'b0}}, pl_reg});

    assign coef_ext = {{(ACC_W-COEF_W-FRAC_SHIFT){m_reg.cn0[COEF_W-1]}}, m_reg.cn0,
                       {FRAC_SHIFT{1'b0}}};

    // floor to q24 is a plain bit select of the signed product
    always_comb
    begin
        out_next     = m_reg;
        out_next.acc = prod[ACC_W+Q24_SH-1:Q24_SH] + coef_ext;
        out_next.cn0 = m_reg.cn1;
        out_next.cn1 = m_reg.cn2;
        out_next.cn2 = '0;
    end

endmodule

`default_nettype wire

// ----- src/bck_scale_step.sv -----
// ---------------------------------------------------------------------------
// bck_scale_step: multiply the magnitude by inv_scale or by 2^16
// chunked partial products, then sum and cap at the saturation bound
// ---------------------------------------------------------------------------
`default_nettype none

module bck_scale_step (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bck_pkg::INV_W-1:0] inv_scale,
    input  logic                      in_vld,
    output logic                      in_rdy,
    input  bck_pkg::sc_t              in_word,
    output logic                      out_vld,
    input  logic                      out_rdy,
    output bck_pkg::sc_t              out_word
);
    import bck_pkg::*;

    logic              vld_m_reg;
    logic              vld_a_reg;
    logic              en_m;
    logic              en_a;
    logic [INV_W-1:0]  factor;
    logic [PP_W-1:0]   pp_reg [N_CHUNK];
    logic [PP_W-1:0]   pp_next [N_CHUNK];
    sc_t               m_reg;
    sc_t               m_next;
    sc_t               out_reg;
    sc_t               out_next;
    logic [WIDE_W-1:0] wide;

    assign en_a     = ~vld_a_reg | out_rdy;
    assign en_m     = ~vld_m_reg | en_a;
    assign in_rdy   = en_m;
    assign out_vld  = vld_a_reg;
    assign out_word = out_reg;

    // once the powers are used up the step only shifts by 16
    assign factor = (in_word.pow != '0) ? inv_scale : ONE_Q16;

    always_comb
    begin
        for (int k = 0; k < N_CHUNK; k++)
        begin
            pp_next[k] = in_word.val[k*CHUNK_W +: CHUNK_W] * factor;
        end
        m_next = in_word;
        if (in_word.pow != '0)
        begin
            m_next.pow = in_word.pow - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
            vld_a_reg <= 1'b0;
        end
        else
        begin
            if (en_m)
            begin
                vld_m_reg <= in_vld;
            end
            if (en_a)
            begin
                vld_a_reg <= vld_m_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_m)
        begin
            pp_reg <= pp_next;
            m_reg  <= m_next;
        end
        if (en_a)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        wide = '0;
        for (int k = 0; k < N_CHUNK; k++)
        begin
            wide = wide + ({{(WIDE_W-PP_W){1'b0}}, pp_reg[k]} << (k * CHUNK_W));
        end
        out_next = m_reg;
        if (wide[WIDE_W-1:VAL_W-1] != '0)
        begin
            out_next.val = VAL_CAP;
        end
        else
        begin
            out_next.val = wide[VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- src/bck_div6_out.sv -----
// ---------------------------------------------------------------------------
// bck_div6_out: divide the scaled magnitude by six, apply sign and saturate
// holds the output register of the core
// ---------------------------------------------------------------------------
`default_nettype none

module bck_div6_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    output logic                         in_rdy,
    input  bck_pkg::sc_t                 in_word,
    output logic                         out_vld,
    input  logic                         out_rdy,
    output logic [bck_pkg::WEIGHT_W-1:0] weight,
    output logic                         last
);
    import bck_pkg::*;

    logic                  vld_d_reg;
    logic                  vld_q_reg;
    logic                  en_d;
    logic                  en_q;
    logic [U_W-1:0]        u;
    logic [A21_W-1:0]      a21_reg;
    logic [A21_W-1:0]      a21_next;
    logic [DS_W-1:0]       s_reg;
    logic [DS_W-1:0]       s_next;
    logic                  sat_reg;
    logic                  neg_d_reg;
    logic                  sup_d_reg;
    logic                  last_d_reg;
    logic [2*DS_W-1:0]     s_mul;
    logic [WEIGHT_W-1:0]   q;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [WEIGHT_W-1:0]   weight_next;
    logic                  last_reg;

    assign en_q    = ~vld_q_reg | out_rdy;
    assign en_d    = ~vld_d_reg | en_q;
    assign in_rdy  = en_d;
    assign out_vld = vld_q_reg;
    assign weight  = weight_reg;
    assign last    = last_reg;

    // u = v / 2, then u / 3 = a * 21845 + (a + b) / 3 with u = a * 2^16 + b
    assign u        = in_word.val[VAL_W-1:V_SHIFT+1];
    assign a21_next = u[DA_W+DB_W-1:DB_W] * K_21845;
    assign s_next   = {1'b0, u[DA_W+DB_W-1:DB_W]} + {{(DS_W-DB_W){1'b0}}, u[DB_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (en_d)
            begin
                vld_d_reg <= in_vld;
            end
            if (en_q)
            begin
                vld_q_reg <= vld_d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            a21_reg    <= a21_next;
            s_reg      <= s_next;
            sat_reg    <= (u >= SAT_U);
            neg_d_reg  <= in_word.neg;
            sup_d_reg  <= in_word.in_sup;
            last_d_reg <= in_word.last;
        end
        if (en_q)
        begin
            weight_reg <= weight_next;
            last_reg   <= last_d_reg;
        end
    end

    assign s_mul = s_reg * DIV3_M;
    assign q     = a21_reg + {{(WEIGHT_W-(2*DS_W-DIV3_SH)){1'b0}}, s_mul[2*DS_W-1:DIV3_SH]};

    always_comb
    begin
        if (!sup_d_reg)
        begin
            weight_next = '0;
        end
        else if (sat_reg)
        begin
            weight_next = neg_d_reg ? W_MIN : W_MAX;
        end
        else
        begin
            weight_next = neg_d_reg ? (~q + 1'b1) : q;
        end
    end

endmodule

`default_nettype wire

// ----- src/bc_cubic_kernel_weight_core.sv -----
// ---------------------------------------------------------------------------
// bc_cubic_kernel_weight_core: bc-family cubic kernel and derivatives
// streams one weight per sample offset through a 17-stage pipeline
// ---------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled; stages from
//   s_axis accept to m_axis_tvalid: t multiply, coefficient select,
//   3 horner steps of 2 stages, magnitude, 3 scale multiplies of 2 stages,
//   divide by six, output
// backpressure: s_axis_tready drops only when all 17 stages hold a word
// reset: rst_n is asynchronous; clears every valid bit and loads the config
//   defaults (kernel value, b = 0, c = 0.5, inv_scale = 1.0)
`default_nettype none

module bc_cubic_kernel_weight_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [bck_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bck_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // offset stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,   // [23:0] sample_offset
    input  logic                           s_axis_tlast,
    // weight stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [31:0] weight
    output logic                           m_axis_tlast
);
    import bck_pkg::*;

    // configuration registers
    logic [ORD_W-1:0]          ord_reg;
    logic signed [SHAPE_W-1:0] shape_b_reg;
    logic signed [SHAPE_W-1:0] shape_c_reg;
    logic [INV_W-1:0]          inv_scale_reg;
    cfg_t                      cfg;

    // stage handshakes along the chain
    logic coef_vld;
    logic coef_rdy;
    logic h1_in_rdy;
    logic h1_vld;
    logic h2_in_rdy;
    logic h2_vld;
    logic h3_in_rdy;
    logic h3_vld;
    logic mag_in_rdy;
    logic vld_mag_reg;
    logic s1_in_rdy;
    logic s1_vld;
    logic s2_in_rdy;
    logic s2_vld;
    logic s3_in_rdy;
    logic s3_vld;
    logic div_in_rdy;

    hn_t              coef_word;
    hn_t              h1_word;
    hn_t              h2_word;
    hn_t              h3_word;
    sc_t              mag_reg;
    sc_t              mag_next;
    sc_t              s1_word;
    sc_t              s2_word;
    sc_t              s3_word;
    logic [MAG_W-1:0] mag;
    logic [ACC_W-1:0] acc_abs;

    // config writes; the user must issue them only while the pipeline is empty, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_reg       <= ORD_RST;
            shape_b_reg   <= SHAPE_B_RST;
            shape_c_reg   <= SHAPE_C_RST;
            inv_scale_reg <= INV_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ORDER:     ord_reg       <= cfg_wdata[ORD_W-1:0];
                REG_SHAPE_B:   shape_b_reg   <= cfg_wdata[SHAPE_W-1:0];
                REG_SHAPE_C:   shape_c_reg   <= cfg_wdata[SHAPE_W-1:0];
                REG_INV_SCALE: inv_scale_reg <= cfg_wdata[INV_W-1:0];
                default:       ;
            endcase
        end
    end

    // unused order code 3 behaves as the second derivative
    always_comb
    begin
        cfg.ord       = (ord_reg == ORD_KERNEL || ord_reg == ORD_FIRST) ? ord_reg
                                                                         : ORD_SECOND;
        cfg.shape_b   = shape_b_reg;
        cfg.shape_c   = shape_c_reg;
        cfg.inv_scale = inv_scale_reg;
    end

    // t = |x| / s, piece select and coefficients
    bck_coef u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_vld  (s_axis_tvalid),
        .in_rdy  (coef_rdy),
        .x       (s_axis_tdata[X_W-1:0]),
        .last    (s_axis_tlast),
        .out_vld (coef_vld),
        .out_rdy (h1_in_rdy),
        .out     (coef_word)
    );

    assign s_axis_tready = coef_rdy;

    // horner evaluation, one step per degree
    bck_horner_step u_horner1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (coef_vld),
        .in_rdy   (h1_in_rdy),
        .in_word  (coef_word),
        .out_vld  (h1_vld),
        .out_rdy  (h2_in_rdy),
        .out_word (h1_word)
    );

    bck_horner_step u_horner2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (h1_vld),
        .in_rdy   (h2_in_rdy),
        .in_word  (h1_word),
        .out_vld  (h2_vld),
        .out_rdy  (h3_in_rdy),
        .out_word (h2_word)
    );

    bck_horner_step u_horner3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (h2_vld),
        .in_rdy   (h3_in_rdy),
        .in_word  (h2_word),
        .out_vld  (h3_vld),
        .out_rdy  (mag_in_rdy),
        .out_word (h3_word)
    );

    // sign and magnitude; first derivative flips sign for negative offsets
    assign acc_abs = h3_word.acc[ACC_W-1] ? (~h3_word.acc + 1'b1) : h3_word.acc;
    assign mag     = acc_abs[MAG_W-1:0];

    always_comb
    begin
        mag_next.val    = {{(VAL_W-MAG_W){1'b0}}, mag};
        mag_next.pow    = cfg.ord + 1'b1;
        mag_next.neg    = h3_word.acc[ACC_W-1] ^ h3_word.side.odd_neg;
        mag_next.in_sup = h3_word.side.in_sup;
        mag_next.last   = h3_word.side.last;
    end

    assign mag_in_rdy = ~vld_mag_reg | s1_in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_mag_reg <= 1'b0;
        end
        else if (mag_in_rdy)
        begin
            vld_mag_reg <= h3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mag_in_rdy)
        begin
            mag_reg <= mag_next;
        end
    end

    // magnitude times inv_scale^(order+1), left aligned by 2^16 per unused power
    bck_scale_step u_scale1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv_scale (inv_scale_reg),
        .in_vld    (vld_mag_reg),
        .in_rdy    (s1_in_rdy),
        .in_word   (mag_reg),
        .out_vld   (s1_vld),
        .out_rdy   (s2_in_rdy),
        .out_word  (s1_word)
    );

    bck_scale_step u_scale2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv_scale (inv_scale_reg),
        .in_vld    (s1_vld),
        .in_rdy    (s2_in_rdy),
        .in_word   (s1_word),
        .out_vld   (s2_vld),
        .out_rdy   (s3_in_rdy),
        .out_word  (s2_word)
    );

    bck_scale_step u_scale3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .inv_scale (inv_scale_reg),
        .in_vld    (s2_vld),
        .in_rdy    (s3_in_rdy),
        .in_word   (s2_word),
        .out_vld   (s3_vld),
        .out_rdy   (div_in_rdy),
        .out_word  (s3_word)
    );

    // divide by six, saturate, output register
    bck_div6_out u_div6 (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (s3_vld),
        .in_rdy  (div_in_rdy),
        .in_word (s3_word),
        .out_vld (m_axis_tvalid),
        .out_rdy (m_axis_tready),
        .weight  (m_axis_tdata),
        .last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- src/bck_checker.sv -----
// ---------------------------------------------------------------------------
// bck_checker: port-level checks for the bc cubic kernel weight core
// tracks words in flight and checks output and backpressure behavior
// ---------------------------------------------------------------------------
`default_nettype none

module bck_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast
);
    import bck_pkg::*;

    logic               in_acc;
    logic               out_acc;
    logic [DEPTH_W-1:0] cnt_reg;
    logic [DEPTH_W-1:0] cnt_next;
    logic [24:0]        in_seen;

    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign out_acc = m_axis_tvalid & m_axis_tready;
    // input payload only matters when accepted
    assign in_seen = in_acc ? {s_axis_tlast, s_axis_tdata} : '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!in_acc && out_acc)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // no result without a word in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (cnt_reg != '0) || (in_seen != '0) || in_acc)
        else $error("output word with nothing in flight");

    // never more words in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= PIPE_DEPTH)
        else $error("more words in flight than pipeline stages");

    // input is only held off when the output is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is free");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output word changed");

endmodule

bind bc_cubic_kernel_weight_core bck_checker u_bck_checker (.*);

`default_nettype wire
